FILE: sv/ccnm_pkg.sv
// Shared widths, register indexes and defaults for the cover-crop coordinate map.
// No dependencies; imported by the core and the checker.
`timescale 1ns / 1ps

package ccnm_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_REGS  = 4;
    localparam int IN_W      = 12;
    localparam int OUT_W     = 12;
    localparam int MAX_DIM_DEF = 4096;
    localparam int CNT_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

endpackage

FILE: sv/cover_crop_nearest_coord_map_core.sv
// Cover-crop nearest-neighbor coordinate map: destination pixel to sampled source pixel.
// Path: capture, crop pick, crop divide, crop window, centers, sample divide, output.
// Throughput one word per clock unless i_stall holds; two division rows: crop, then sample.
// Bubbles collapse, so words keep entering while a result waits at the output.
// Synchronous active-low reset sets all four size registers to 1 and empties the pipeline.
// Depends on ccnm_pkg and ccnm_div_chain.
`timescale 1ns / 1ps

module cover_crop_nearest_coord_map_core
    import ccnm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_W-1:0]      i_dst_x,
    input  logic [IN_W-1:0]      i_dst_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_src_x,
    output logic [OUT_W-1:0]     o_src_y
);

    localparam int E     = $clog2(MAX_DIM + 1);
    localparam int PRW   = 2 * E;
    localparam int NUM_W = IN_W + 1 + E;
    localparam int MDV_W = E + 1;
    localparam int CPW   = 2 + 2 * IN_W;

    typedef enum logic [1:0] {
        CROP_FULL = 2'd0,
        CROP_X    = 2'd1,
        CROP_Y    = 2'd2
    } t_crop_mode;

    function automatic logic [E-1:0] f_eff(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return E'(1);
        end else if (32'(v) > MAX_DIM) begin
            return E'(MAX_DIM);
        end else begin
            return E'(v);
        end
    endfunction

    logic [NUM_REGS-1:0][CFG_W-1:0] r_cfg;
    logic [E-1:0] sw, sh, dw, dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= CFG_W'(1);
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign sw = f_eff(r_cfg[REG_SRC_WIDTH]);
    assign sh = f_eff(r_cfg[REG_SRC_HEIGHT]);
    assign dw = f_eff(r_cfg[REG_DST_WIDTH]);
    assign dh = f_eff(r_cfg[REG_DST_HEIGHT]);

    // stage 0: capture the word, form both cross products
    logic            r0_v;
    logic [IN_W-1:0] r0_dx, r0_dy;
    logic [PRW-1:0]  r0_wide, r0_tall;
    logic            ready0, ready1, ready2, ready3, ready_out;
    logic            cready, mready;

    assign ready0  = !r0_v || ready1;
    assign o_stall = !ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (ready0) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready0) begin
            r0_dx   <= i_dst_x;
            r0_dy   <= i_dst_y;
            r0_wide <= PRW'(sw) * PRW'(dh);
            r0_tall <= PRW'(sh) * PRW'(dw);
        end
    end

    // stage 1: pick the cropped axis and its division
    logic            r1_v;
    logic [IN_W-1:0] r1_dx, r1_dy;
    t_crop_mode      r1_mode, n1_mode;
    logic [PRW-1:0]  r1_num, n1_num;
    logic [E-1:0]    r1_div, n1_div;

    assign ready1 = !r1_v || cready;

    always_comb begin
        if (r0_wide > r0_tall) begin
            n1_mode = CROP_X;
            n1_num  = r0_tall;
            n1_div  = dh;
        end else if (r0_wide < r0_tall) begin
            n1_mode = CROP_Y;
            n1_num  = r0_wide;
            n1_div  = dw;
        end else begin
            n1_mode = CROP_FULL;
            n1_num  = r0_wide;
            n1_div  = dw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (ready1) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1_dx   <= r0_dx;
            r1_dy   <= r0_dy;
            r1_mode <= n1_mode;
            r1_num  <= n1_num;
            r1_div  <= n1_div;
        end
    end

    logic                       c_v;
    logic [0:0][E+PRW-1:0]      c_word_in, c_word;
    logic [0:0][E-1:0]          c_div_in;
    logic [CPW-1:0]             c_pay;

    assign c_word_in[0] = {{E{1'b0}}, r1_num};
    assign c_div_in[0]  = r1_div;

    ccnm_div_chain #(
        .NL  (1),
        .DVW (E),
        .NW  (PRW),
        .PW  (CPW)
    ) u_crop_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_word  (c_word_in),
        .i_div   (c_div_in),
        .i_pay   ({r1_mode, r1_dx, r1_dy}),
        .o_ready (cready),
        .o_valid (c_v),
        .o_word  (c_word),
        .o_pay   (c_pay),
        .i_ready (ready2)
    );

    // stage 2: crop window per axis
    logic            r2_v;
    logic [IN_W-1:0] r2_dx, r2_dy;
    logic [E-1:0]    r2_cw, r2_ch, r2_cx, r2_cy;
    logic [E-1:0]    n2_cw, n2_ch, n2_cx, n2_cy, crop;
    logic [PRW-1:0]  cq;
    logic [E-1:0]    sdiff;
    t_crop_mode      c_mode;

    assign ready2 = !r2_v || ready3;
    assign cq     = c_word[0][PRW-1:0];
    assign crop   = (cq == '0) ? E'(1) : cq[E-1:0];
    assign c_mode = t_crop_mode'(c_pay[CPW-1:CPW-2]);

    always_comb begin
        n2_cw = sw;
        n2_ch = sh;
        n2_cx = '0;
        n2_cy = '0;
        sdiff = '0;
        case (c_mode)
            CROP_X: begin
                sdiff = sw - crop;
                n2_cw = crop;
                n2_cx = sdiff >> 1;
            end
            CROP_Y: begin
                sdiff = sh - crop;
                n2_ch = crop;
                n2_cy = sdiff >> 1;
            end
            default: begin
                sdiff = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (ready2) begin
            r2_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2_dx <= c_pay[2*IN_W-1:IN_W];
            r2_dy <= c_pay[IN_W-1:0];
            r2_cw <= n2_cw;
            r2_ch <= n2_ch;
            r2_cx <= n2_cx;
            r2_cy <= n2_cy;
        end
    end

    // stage 3: pixel-center numerators
    logic             r3_v;
    logic [NUM_W-1:0] r3_numx, r3_numy;
    logic [E-1:0]     r3_cx, r3_cy;

    assign ready3 = !r3_v || mready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (ready3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r3_numx <= NUM_W'({r2_dx, 1'b1}) * NUM_W'(r2_cw);
            r3_numy <= NUM_W'({r2_dy, 1'b1}) * NUM_W'(r2_ch);
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
        end
    end

    logic                        m_v;
    logic [1:0][MDV_W+NUM_W-1:0] m_word_in, m_word;
    logic [1:0][MDV_W-1:0]       m_div_in;
    logic [2*E-1:0]              m_pay;

    assign m_word_in[0] = {{MDV_W{1'b0}}, r3_numx};
    assign m_word_in[1] = {{MDV_W{1'b0}}, r3_numy};
    assign m_div_in[0]  = {dw, 1'b0};
    assign m_div_in[1]  = {dh, 1'b0};

    ccnm_div_chain #(
        .NL  (2),
        .DVW (MDV_W),
        .NW  (NUM_W),
        .PW  (2 * E)
    ) u_map_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_word  (m_word_in),
        .i_div   (m_div_in),
        .i_pay   ({r3_cx, r3_cy}),
        .o_ready (mready),
        .o_valid (m_v),
        .o_word  (m_word),
        .o_pay   (m_pay),
        .i_ready (ready_out)
    );

    // output register: add crop offset, clamp to source size
    logic               r_out_v;
    logic [OUT_W-1:0]   r_out_x, r_out_y;
    logic [NUM_W:0]     sum_x, sum_y;
    logic [E-1:0]       n_sx, n_sy;

    assign ready_out = !r_out_v || !i_stall;
    assign sum_x = (NUM_W+1)'(m_pay[2*E-1:E]) + (NUM_W+1)'(m_word[0][NUM_W-1:0]);
    assign sum_y = (NUM_W+1)'(m_pay[E-1:0]) + (NUM_W+1)'(m_word[1][NUM_W-1:0]);
    assign n_sx  = (sum_x >= (NUM_W+1)'(sw)) ? sw - E'(1) : sum_x[E-1:0];
    assign n_sy  = (sum_y >= (NUM_W+1)'(sh)) ? sh - E'(1) : sum_y[E-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ready_out) begin
            r_out_v <= m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            r_out_x <= OUT_W'(n_sx);
            r_out_y <= OUT_W'(n_sy);
        end
    end

    assign o_valid = r_out_v;
    assign o_src_x = r_out_x;
    assign o_src_y = r_out_y;

endmodule

FILE: sv/ccnm_div_cell.sv
// One restoring-division step per lane, registered, with a ready ripple to the left.
// Standalone; instantiated in a row by ccnm_div_chain.
`timescale 1ns / 1ps

module ccnm_div_cell #(
    parameter int NL  = 1,
    parameter int DVW = 8,
    parameter int NW  = 16,
    parameter int PW  = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [NL-1:0][DVW+NW-1:0]      i_word,
    input  logic [NL-1:0][DVW-1:0]         i_div,
    input  logic [PW-1:0]                  i_pay,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [NL-1:0][DVW+NW-1:0]      o_word,
    output logic [NL-1:0][DVW-1:0]         o_div,
    output logic [PW-1:0]                  o_pay,
    input  logic                           i_ready
);

    logic                      r_valid;
    logic [NL-1:0][DVW+NW-1:0] r_word;
    logic [NL-1:0][DVW-1:0]    r_div;
    logic [PW-1:0]             r_pay;
    logic [NL-1:0][DVW+NW-1:0] n_word;

    always_comb begin
        logic [DVW+NW:0] sh;
        logic [DVW:0]    top;
        logic [DVW:0]    diff;
        for (int l = 0; l < NL; l++) begin
            sh   = {i_word[l], 1'b0};
            top  = sh[DVW+NW:NW];
            diff = top - {1'b0, i_div[l]};
            if (top >= {1'b0, i_div[l]}) begin
                n_word[l] = {diff[DVW-1:0], sh[NW-1:1], 1'b1};
            end else begin
                n_word[l] = sh[DVW+NW-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= n_word;
            r_div  <= i_div;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_div   = r_div;
    assign o_pay   = r_pay;

endmodule

FILE: sv/ccnm_div_chain.sv
// Row of NW division cells: one quotient bit per cell, the remainder handed right.
// Depends on ccnm_div_cell.
`timescale 1ns / 1ps

module ccnm_div_chain #(
    parameter int NL  = 1,
    parameter int DVW = 8,
    parameter int NW  = 16,
    parameter int PW  = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [NL-1:0][DVW+NW-1:0]      i_word,
    input  logic [NL-1:0][DVW-1:0]         i_div,
    input  logic [PW-1:0]                  i_pay,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [NL-1:0][DVW+NW-1:0]      o_word,
    output logic [PW-1:0]                  o_pay,
    input  logic                           i_ready
);

    logic [NW:0]                          valid;
    logic [NW:0]                          ready;
    logic [NW:0][NL-1:0][DVW+NW-1:0]      word;
    logic [NW:0][NL-1:0][DVW-1:0]         dvs;
    logic [NW:0][PW-1:0]                  pay;

    assign valid[0]  = i_valid;
    assign word[0]   = i_word;
    assign dvs[0]    = i_div;
    assign pay[0]    = i_pay;
    assign ready[NW] = i_ready;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        ccnm_div_cell #(
            .NL  (NL),
            .DVW (DVW),
            .NW  (NW),
            .PW  (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .i_word  (word[k]),
            .i_div   (dvs[k]),
            .i_pay   (pay[k]),
            .o_ready (ready[k]),
            .o_valid (valid[k+1]),
            .o_word  (word[k+1]),
            .o_div   (dvs[k+1]),
            .o_pay   (pay[k+1]),
            .i_ready (ready[k+1])
        );
    end

    assign o_ready = ready[0];
    assign o_valid = valid[NW];
    assign o_word  = word[NW];
    assign o_pay   = pay[NW];

endmodule

FILE: sv/ccnm_checker.sv
// Port-level checks for cover_crop_nearest_coord_map_core, attached by bind.
// Depends on ccnm_pkg; sees only the top-level ports.
`timescale 1ns / 1ps

module ccnm_checker
    import ccnm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [OUT_W-1:0]     o_src_x,
    input  logic [OUT_W-1:0]     o_src_y
);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_src_x) && $stable(o_src_y))
        else $error("stalled output word changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("output word without an accepted input word");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !o_stall)
        else $error("input stalled while pipeline empty");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_cnt == '0)
        else $error("size register written with words in flight");

endmodule

bind cover_crop_nearest_coord_map_core ccnm_checker u_ccnm_checker (.*);
